@@ rtl/tdpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared command and status types between the trial division controller and
// its datapath.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  // Commands from the controller to the datapath, at most one per cycle
  typedef struct packed {
    logic load;       // capture a new candidate, reset divisor to three
    logic div_start;  // prime the remainder unit with the candidate
    logic div_step;   // one restoring division step
    logic next_d;     // advance to the next odd divisor
  } tdpt_cmd_t;

  // Flags from the datapath, all derived from registered values
  typedef struct packed {
    logic neg;        // candidate has its sign bit set
    logic le1;        // candidate is zero or one
    logic le3;        // candidate is three or less
    logic even;       // candidate is even
    logic sq_gt_n;    // divisor squared exceeds the candidate
    logic rem_zero;   // remainder of the last division is zero
    logic div_last;   // the remainder unit is on its final step
  } tdpt_status_t;

endpackage

@@ rtl/tdpt_if.sv @@
// ----------------------------------------------------------------------------
// tdpt_if
// Valid/ready channels for the candidate stream and the result stream.
// ----------------------------------------------------------------------------
interface tdpt_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_out_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

@@ rtl/tdpt_dpath.sv @@
// ----------------------------------------------------------------------------
// tdpt_dpath
// Candidate, odd divisor and its square, plus a one-bit-per-cycle restoring
// remainder unit.
// ----------------------------------------------------------------------------
module tdpt_dpath #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [DATA_WIDTH-1:0] candidate,
  input  tdpt_pkg::tdpt_cmd_t          cmd,
  output tdpt_pkg::tdpt_status_t       status
);
  import tdpt_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] n_r,   n_nxt;
  logic [DATA_WIDTH-1:0] d_r,   d_nxt;
  logic [DATA_WIDTH:0]   sq_r,  sq_nxt;
  logic [DATA_WIDTH-1:0] div_r, div_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;

  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  fits;

  // Restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {rem_r, div_r[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, d_r};
  assign fits  = trial >= {1'b0, d_r};

  always_comb begin
    n_nxt   = n_r;
    d_nxt   = d_r;
    sq_nxt  = sq_r;
    div_nxt = div_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      n_nxt  = DATA_WIDTH'(candidate);
      d_nxt  = DATA_WIDTH'(3);
      sq_nxt = (DATA_WIDTH+1)'(9);
    end
    if (cmd.div_start) begin
      div_nxt = n_r;
      rem_nxt = '0;
      cnt_nxt = '0;
    end
    if (cmd.div_step) begin
      div_nxt = {div_r[DATA_WIDTH-2:0], 1'b0};
      rem_nxt = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      cnt_nxt = cnt_r + CW'(1);
    end
    if (cmd.next_d) begin
      // (d + 2)^2 = d^2 + 4d + 4
      d_nxt  = d_r + DATA_WIDTH'(2);
      sq_nxt = sq_r + {d_r[DATA_WIDTH-2:0], 2'b00} + (DATA_WIDTH+1)'(4);
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    sq_r  <= sq_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign status.neg      = n_r[DATA_WIDTH-1];
  assign status.le1      = n_r <= DATA_WIDTH'(1);
  assign status.le3      = n_r <= DATA_WIDTH'(3);
  assign status.even     = ~n_r[0];
  assign status.sq_gt_n  = sq_r > {1'b0, n_r};
  assign status.rem_zero = rem_r == '0;
  assign status.div_last = cnt_r == CW'(DATA_WIDTH-1);

  // Divisor advances by exactly two and stays odd
  a_next_d_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.next_d |=> (d_r == $past(d_r) + DATA_WIDTH'(2)) && d_r[0])
    else $error("divisor did not advance to the next odd value");

endmodule

@@ rtl/tdpt_ctrl.sv @@
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Sequencer for the trial division: classifies the candidate, runs one
// remainder per odd divisor, and posts the verdict into the result register.
// ----------------------------------------------------------------------------
module tdpt_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_is_prime,
  output tdpt_pkg::tdpt_cmd_t    cmd,
  input  tdpt_pkg::tdpt_status_t status
);
  import tdpt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLASS = 3'd1;
  localparam logic [2:0] S_LOOP  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_REM   = 3'd4;
  localparam logic [2:0] S_POST  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_is_prime_r, out_is_prime_nxt;

  always_comb begin
    state_nxt        = state_r;
    res_nxt          = res_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_is_prime_nxt = out_is_prime_r;
    cmd              = '0;
    in_ready         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        if (status.neg || status.le1) begin
          res_nxt   = 1'b0;
          state_nxt = S_POST;
        end else if (status.le3) begin
          res_nxt   = 1'b1;
          state_nxt = S_POST;
        end else if (status.even) begin
          res_nxt   = 1'b0;
          state_nxt = S_POST;
        end else begin
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        // past the square root with no factor found
        if (status.sq_gt_n) begin
          res_nxt   = 1'b1;
          state_nxt = S_POST;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_REM;
        end
      end
      S_REM: begin
        if (status.rem_zero) begin
          res_nxt   = 1'b0;
          state_nxt = S_POST;
        end else begin
          cmd.next_d = 1'b1;
          state_nxt  = S_LOOP;
        end
      end
      S_POST: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = res_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_r          <= res_nxt;
    out_is_prime_r <= out_is_prime_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

  a_accept_class: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_CLASS)
    else $error("accepted beat did not start classification");

  a_result_from_post: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_POST))
    else $error("result raised outside the post state");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && status.div_last) |=> state_r == S_REM)
    else $error("remainder unit overran its last step");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.div_start, cmd.div_step, cmd.next_d}))
    else $error("conflicting datapath commands");

endmodule

@@ rtl/trial_division_prime_test.sv @@
// Flow: an accepted beat is classified; negative, 0..3 and even candidates go straight
//   to the result. Otherwise each odd divisor from three is tried in turn by the bit-serial
//   remainder unit (DATA_WIDTH steps per divisor) until one divides the candidate or its
//   square exceeds the candidate, which marks a prime. One candidate in flight at a time;
//   the next beat is taken while the previous result waits in the output register.
// Reset: synchronous active-low rst_n clears the sequencer and the result valid.
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test by trial division over odd divisors up to the square root.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  tdpt_in_if.sink   in_ch,
  tdpt_out_if.source out_ch
);
  import tdpt_pkg::*;

  tdpt_cmd_t    cmd;
  tdpt_status_t status;

  tdpt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_is_prime (out_ch.is_prime),
    .cmd          (cmd),
    .status       (status)
  );

  tdpt_dpath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .candidate (in_ch.candidate),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
